// ===== src/bwts_pkg.sv =====
// shared types and constants for the bilinear wrap texture sampler
package bwts_pkg;
    localparam int FRAC_BITS = 16;
    localparam int CHANNEL_BITS = 16;
    localparam int SIDE_BITS = 8;
    localparam int MAX_SIDE = 1 << SIDE_BITS;
    localparam int COORD_BITS = 24;
    localparam int SIZE_BITS = SIDE_BITS + 1;
    localparam int ADDR_BITS = 2 * SIDE_BITS;
    localparam int BANK_ADDR_BITS = ADDR_BITS - 2;
    localparam int TEXEL_BITS = 3 * CHANNEL_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 48;
    localparam int FQ_DEPTH = 4;
    localparam int FQ_PTR_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_U_SCALE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_U_OFFSET = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_SCALE = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_V_OFFSET = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_WIDTH = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEX_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_TEXTURE_ON = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLAT_COLOR = 3'd7;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [SIDE_BITS-1:0]      texel_col;
        logic [SIDE_BITS-1:0]      texel_row;
        logic [CHANNEL_BITS-1:0]   texel_red;
        logic [CHANNEL_BITS-1:0]   texel_green;
        logic [CHANNEL_BITS-1:0]   texel_blue;
        logic signed [COORD_BITS-1:0] u_coord;
        logic signed [COORD_BITS-1:0] v_coord;
    } in_item_t;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] out_red;
        logic [CHANNEL_BITS-1:0] out_green;
        logic [CHANNEL_BITS-1:0] out_blue;
        logic                    from_texture;
    } out_item_t;

    // front to back: one classified item
    typedef struct packed {
        logic                    is_write;
        logic                    use_tex;
        logic [ADDR_BITS-1:0]    waddr;
        logic [TEXEL_BITS-1:0]   wdata;
        logic [SIDE_BITS-1:0]    x;
        logic [SIDE_BITS-1:0]    nx;
        logic [SIDE_BITS-1:0]    y;
        logic [SIDE_BITS-1:0]    ny;
        logic [FRAC_BITS-1:0]    dx;
        logic [FRAC_BITS-1:0]    dy;
        logic [TEXEL_BITS-1:0]   flat;
    } job_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] u_scale;
        logic signed [COORD_BITS-1:0] u_offset;
        logic signed [COORD_BITS-1:0] v_scale;
        logic signed [COORD_BITS-1:0] v_offset;
        logic [SIZE_BITS-1:0]         tex_width;
        logic [SIZE_BITS-1:0]         tex_height;
        logic                         texture_on;
        logic [TEXEL_BITS-1:0]        flat_color;
    } cfg_t;

    function automatic logic [SIZE_BITS-1:0] clamp_side(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] r;
        begin
            r = s;
            if (s == '0)
            begin
                r = SIZE_BITS'(1);
            end
            else if (s > SIZE_BITS'(MAX_SIDE))
            begin
                r = SIZE_BITS'(MAX_SIDE);
            end
            return r;
        end
    endfunction
endpackage

// ===== src/bwts_stream_if.sv =====
// valid/ready channel carrying one payload
interface bwts_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bwts_cfg.sv =====
// configuration register file
module bwts_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bwts_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [bwts_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output bwts_pkg::cfg_t                    cfg
);
    import bwts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_U_SCALE:    cfg_next.u_scale = cfg_data[COORD_BITS-1:0];
                REG_U_OFFSET:   cfg_next.u_offset = cfg_data[COORD_BITS-1:0];
                REG_V_SCALE:    cfg_next.v_scale = cfg_data[COORD_BITS-1:0];
                REG_V_OFFSET:   cfg_next.v_offset = cfg_data[COORD_BITS-1:0];
                REG_TEX_WIDTH:  cfg_next.tex_width = cfg_data[SIZE_BITS-1:0];
                REG_TEX_HEIGHT: cfg_next.tex_height = cfg_data[SIZE_BITS-1:0];
                REG_TEXTURE_ON: cfg_next.texture_on = cfg_data[0];
                REG_FLAT_COLOR: cfg_next.flat_color = cfg_data[TEXEL_BITS-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.u_scale <= COORD_BITS'(1 << FRAC_BITS);
            cfg_reg.u_offset <= '0;
            cfg_reg.v_scale <= COORD_BITS'(1 << FRAC_BITS);
            cfg_reg.v_offset <= '0;
            cfg_reg.tex_width <= SIZE_BITS'(MAX_SIDE);
            cfg_reg.tex_height <= SIZE_BITS'(MAX_SIDE);
            cfg_reg.texture_on <= 1'b0;
            cfg_reg.flat_color <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== src/bwts_front.sv =====
// front end: coordinate transform, wrap and texel index/weight, three stages
module bwts_front (
    input  logic           clk,
    input  logic           rst_n,
    input  bwts_pkg::cfg_t cfg,
    bwts_stream_if.sink    in_ch,
    output logic           job_valid,
    output bwts_pkg::job_t job,
    input  logic           job_ready
);
    import bwts_pkg::*;

    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int FR_BITS = 2 * FRAC_BITS;
    localparam int POS_BITS = FR_BITS + SIZE_BITS;

    logic [2:0] v_reg;
    logic       adv;

    // stage 1 registers
    in_item_t                   s1_item_reg;
    logic signed [PROD_BITS-1:0] s1_pu_reg;
    logic signed [PROD_BITS-1:0] s1_pv_reg;
    // stage 2 registers
    in_item_t                   s2_item_reg;
    logic [FR_BITS-1:0]         s2_fu_reg;
    logic [FR_BITS-1:0]         s2_fv_reg;
    // stage 3 registers
    in_item_t                   s3_item_reg;
    logic [POS_BITS-1:0]        s3_posu_reg;
    logic [POS_BITS-1:0]        s3_posv_reg;

    logic [SIZE_BITS-1:0] w_side;
    logic [SIZE_BITS-1:0] h_side;
    logic [FR_BITS-1:0]   offu;
    logic [FR_BITS-1:0]   offv;
    logic [SIZE_BITS-1:0] xi;
    logic [SIZE_BITS-1:0] yi;
    logic [SIZE_BITS-1:0] xc;
    logic [SIZE_BITS-1:0] yc;
    logic [SIZE_BITS-1:0] xn;
    logic [SIZE_BITS-1:0] yn;

    assign adv = !v_reg[2] || job_ready;
    assign in_ch.ready = adv;
    assign w_side = clamp_side(cfg.tex_width);
    assign h_side = clamp_side(cfg.tex_height);
    assign offu = FR_BITS'({cfg.u_offset, {FRAC_BITS{1'b0}}});
    assign offv = FR_BITS'({cfg.v_offset, {FRAC_BITS{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[1:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= in_ch.data;
            s1_pu_reg <= PROD_BITS'(cfg.u_scale) * PROD_BITS'(in_ch.data.u_coord);
            s1_pv_reg <= PROD_BITS'(cfg.v_scale) * PROD_BITS'(in_ch.data.v_coord);
            s2_item_reg <= s1_item_reg;
            s2_fu_reg <= FR_BITS'(s1_pu_reg) + offu;
            s2_fv_reg <= FR_BITS'(s1_pv_reg) + offv;
            s3_item_reg <= s2_item_reg;
            s3_posu_reg <= POS_BITS'(s2_fu_reg) * POS_BITS'(w_side);
            s3_posv_reg <= POS_BITS'(s2_fv_reg) * POS_BITS'(h_side);
        end
    end

    always_comb
    begin
        xi = s3_posu_reg[POS_BITS-1:FR_BITS];
        yi = s3_posv_reg[POS_BITS-1:FR_BITS];
        xc = (xi >= w_side) ? w_side - SIZE_BITS'(1) : xi;
        yc = (yi >= h_side) ? h_side - SIZE_BITS'(1) : yi;
        xn = (xc + SIZE_BITS'(1) == w_side) ? '0 : xc + SIZE_BITS'(1);
        yn = (yc + SIZE_BITS'(1) == h_side) ? '0 : yc + SIZE_BITS'(1);
        job.is_write = (s3_item_reg.op == OP_WRITE);
        job.use_tex = cfg.texture_on;
        job.waddr = {s3_item_reg.texel_row, s3_item_reg.texel_col};
        job.wdata = {s3_item_reg.texel_red, s3_item_reg.texel_green,
                     s3_item_reg.texel_blue};
        job.x = xc[SIDE_BITS-1:0];
        job.nx = xn[SIDE_BITS-1:0];
        job.y = yc[SIDE_BITS-1:0];
        job.ny = yn[SIDE_BITS-1:0];
        job.dx = s3_posu_reg[FR_BITS-1:FRAC_BITS];
        job.dy = s3_posv_reg[FR_BITS-1:FRAC_BITS];
        job.flat = cfg.flat_color;
    end

    assign job_valid = v_reg[2];
endmodule

// ===== src/bwts_fifo.sv =====
// short queue between front and back
module bwts_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  bwts_pkg::job_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output bwts_pkg::job_t rd_data
);
    import bwts_pkg::*;

    job_t                 mem_reg [FQ_DEPTH];
    logic [FQ_PTR_BITS-1:0] wp_reg;
    logic [FQ_PTR_BITS-1:0] rp_reg;
    logic [FQ_PTR_BITS:0]   cnt_reg;
    logic                   push;
    logic                   pop;

    assign wr_ready = (cnt_reg != (FQ_PTR_BITS+1)'(FQ_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FQ_PTR_BITS+1)'(push) - (FQ_PTR_BITS+1)'(pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (FQ_PTR_BITS+1)'(FQ_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count mismatch");
endmodule

// ===== src/bwts_back.sv =====
// back end: parity-banked texel store, bilinear blend, output register
module bwts_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    output logic           job_ready,
    input  bwts_pkg::job_t job,
    bwts_stream_if.source  out_ch
);
    import bwts_pkg::*;

    localparam int BANKS = 4;
    localparam int L1_BITS = CHANNEL_BITS + FRAC_BITS + 1;
    localparam int L2_BITS = CHANNEL_BITS + 2 * FRAC_BITS + 2;
    localparam int WT_BITS = FRAC_BITS + 1;

    // banks by (row parity, col parity)
    logic [TEXEL_BITS-1:0] bank0 [1 << BANK_ADDR_BITS];
    logic [TEXEL_BITS-1:0] bank1 [1 << BANK_ADDR_BITS];
    logic [TEXEL_BITS-1:0] bank2 [1 << BANK_ADDR_BITS];
    logic [TEXEL_BITS-1:0] bank3 [1 << BANK_ADDR_BITS];
    // copies of column 0 (by row) and row 0 (by col) for wrapped neighbors
    logic [TEXEL_BITS-1:0] col0_mem [MAX_SIDE];
    logic [TEXEL_BITS-1:0] row0_mem [MAX_SIDE];

    logic [3:0] v_reg;
    logic       adv;
    logic       take;

    logic [BANK_ADDR_BITS-1:0] ra [BANKS];
    logic [1:0]                wbank;
    logic [BANK_ADDR_BITS-1:0] wa;
    logic                      we;
    logic                      wrap_x;
    logic                      wrap_y;

    // stage A: read data and routing
    logic [TEXEL_BITS-1:0] rd_reg [BANKS];
    logic [TEXEL_BITS-1:0] c0_rd_reg [2];
    logic [TEXEL_BITS-1:0] r0_rd_reg [2];
    logic                  a_wrapx_reg;
    logic                  a_wrapy_reg;
    logic                  a_sample_reg;
    logic                  a_tex_reg;
    logic [1:0]            a_sel_reg;
    logic [FRAC_BITS-1:0]  a_dx_reg;
    logic [FRAC_BITS-1:0]  a_dy_reg;
    logic [TEXEL_BITS-1:0] a_flat_reg;
    // stage B: x blend
    logic [L1_BITS-1:0]    b_r0_reg [3];
    logic [L1_BITS-1:0]    b_r1_reg [3];
    logic                  b_sample_reg;
    logic                  b_tex_reg;
    logic [FRAC_BITS-1:0]  b_dy_reg;
    logic [TEXEL_BITS-1:0] b_flat_reg;
    // stage C: y blend
    logic [L2_BITS-1:0]    c_acc_reg [3];
    logic                  c_sample_reg;
    logic                  c_tex_reg;
    logic [TEXEL_BITS-1:0] c_flat_reg;
    // output register
    out_item_t             o_reg;

    logic [TEXEL_BITS-1:0] t00;
    logic [TEXEL_BITS-1:0] t10;
    logic [TEXEL_BITS-1:0] t01;
    logic [TEXEL_BITS-1:0] t11;
    logic [L2_BITS-1:0]    rnd [3];
    out_item_t             o_next;

    assign adv = !v_reg[3] || out_ch.ready;
    assign job_ready = adv;
    assign take = job_valid && adv;
    assign we = take && job.is_write;
    assign wbank = {job.waddr[SIDE_BITS], job.waddr[0]};
    assign wa = {job.waddr[ADDR_BITS-1:SIDE_BITS+1], job.waddr[SIDE_BITS-1:1]};
    assign wrap_x = (job.nx == '0);
    assign wrap_y = (job.ny == '0);

    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            ra[b] = '0;
        end
        // later assignments win; a neighbor that shares a bank after a wrap
        // comes from the row 0 or column 0 copy instead
        ra[{job.ny[0], job.nx[0]}] = {job.ny[SIDE_BITS-1:1], job.nx[SIDE_BITS-1:1]};
        ra[{job.ny[0], job.x[0]}] = {job.ny[SIDE_BITS-1:1], job.x[SIDE_BITS-1:1]};
        ra[{job.y[0], job.nx[0]}] = {job.y[SIDE_BITS-1:1], job.nx[SIDE_BITS-1:1]};
        ra[{job.y[0], job.x[0]}] = {job.y[SIDE_BITS-1:1], job.x[SIDE_BITS-1:1]};
    end

    always_ff @(posedge clk)
    begin
        if (we && wbank == 2'd0)
        begin
            bank0[wa] <= job.wdata;
        end
        if (we && wbank == 2'd1)
        begin
            bank1[wa] <= job.wdata;
        end
        if (we && wbank == 2'd2)
        begin
            bank2[wa] <= job.wdata;
        end
        if (we && wbank == 2'd3)
        begin
            bank3[wa] <= job.wdata;
        end
        if (we && job.waddr[SIDE_BITS-1:0] == '0)
        begin
            col0_mem[job.waddr[ADDR_BITS-1:SIDE_BITS]] <= job.wdata;
        end
        if (we && job.waddr[ADDR_BITS-1:SIDE_BITS] == '0)
        begin
            row0_mem[job.waddr[SIDE_BITS-1:0]] <= job.wdata;
        end
        if (adv)
        begin
            rd_reg[0] <= bank0[ra[0]];
            rd_reg[1] <= bank1[ra[1]];
            rd_reg[2] <= bank2[ra[2]];
            rd_reg[3] <= bank3[ra[3]];
            c0_rd_reg[0] <= col0_mem[job.y];
            c0_rd_reg[1] <= col0_mem[job.ny];
            r0_rd_reg[0] <= row0_mem[job.x];
            r0_rd_reg[1] <= row0_mem[job.nx];
            a_wrapx_reg <= wrap_x;
            a_wrapy_reg <= wrap_y;
            a_sample_reg <= !job.is_write;
            a_tex_reg <= job.use_tex;
            a_sel_reg <= {job.y[0], job.x[0]};
            a_dx_reg <= job.dx;
            a_dy_reg <= job.dy;
            a_flat_reg <= job.flat;
        end
    end

    always_comb
    begin
        // bank order by parity: sel = {y0, x0}; a neighbor without wrap flips the bit
        t00 = rd_reg[a_sel_reg];
        t10 = a_wrapx_reg ? c0_rd_reg[0] : rd_reg[{a_sel_reg[1], ~a_sel_reg[0]}];
        t01 = a_wrapy_reg ? r0_rd_reg[0] : rd_reg[{~a_sel_reg[1], a_sel_reg[0]}];
        t11 = a_wrapx_reg ? c0_rd_reg[1]
            : (a_wrapy_reg ? r0_rd_reg[1] : rd_reg[~a_sel_reg]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                b_r0_reg[c] <=
                    L1_BITS'(t00[c*CHANNEL_BITS +: CHANNEL_BITS])
                        * L1_BITS'(WT_BITS'(1 << FRAC_BITS) - WT_BITS'(a_dx_reg))
                    + L1_BITS'(t10[c*CHANNEL_BITS +: CHANNEL_BITS]) * L1_BITS'(a_dx_reg);
                b_r1_reg[c] <=
                    L1_BITS'(t01[c*CHANNEL_BITS +: CHANNEL_BITS])
                        * L1_BITS'(WT_BITS'(1 << FRAC_BITS) - WT_BITS'(a_dx_reg))
                    + L1_BITS'(t11[c*CHANNEL_BITS +: CHANNEL_BITS]) * L1_BITS'(a_dx_reg);
            end
            b_sample_reg <= a_sample_reg;
            b_tex_reg <= a_tex_reg;
            b_dy_reg <= a_dy_reg;
            b_flat_reg <= a_flat_reg;
            for (int c = 0; c < 3; c++)
            begin
                c_acc_reg[c] <=
                    L2_BITS'(b_r0_reg[c])
                        * L2_BITS'(WT_BITS'(1 << FRAC_BITS) - WT_BITS'(b_dy_reg))
                    + L2_BITS'(b_r1_reg[c]) * L2_BITS'(b_dy_reg);
            end
            c_sample_reg <= b_sample_reg;
            c_tex_reg <= b_tex_reg;
            c_flat_reg <= b_flat_reg;
            o_reg <= o_next;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rnd[c] = c_acc_reg[c] + L2_BITS'(1 << (2 * FRAC_BITS - 1));
        end
        if (c_tex_reg)
        begin
            o_next.out_red = rnd[2][2*FRAC_BITS +: CHANNEL_BITS];
            o_next.out_green = rnd[1][2*FRAC_BITS +: CHANNEL_BITS];
            o_next.out_blue = rnd[0][2*FRAC_BITS +: CHANNEL_BITS];
        end
        else
        begin
            o_next.out_red = c_flat_reg[2*CHANNEL_BITS +: CHANNEL_BITS];
            o_next.out_green = c_flat_reg[CHANNEL_BITS +: CHANNEL_BITS];
            o_next.out_blue = c_flat_reg[0 +: CHANNEL_BITS];
        end
        o_next.from_texture = c_tex_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:0], take && !job.is_write};
        end
    end

    assign out_ch.valid = v_reg[3];
    assign out_ch.data = o_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && job.is_write) |=> !v_reg[0])
        else $error("texel write produced a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && !job.is_write) |=> v_reg[0])
        else $error("sample lost entering back end");
endmodule

// ===== src/bilinear_wrap_texture_sampler.sv =====
// top level of the bilinear wrap texture sampler
// Accepts one item per cycle while the output is not stalled and returns one
// result per sample item. A sample result passes through three front stages
// (coordinate multiply, wrap, side multiply), the job queue, then texel read
// from four parity banks, x blend, y blend and the output register.
// Texel writes take the same path and produce no result. The four banks, with
// copies of row 0 and column 0 for neighbors that wrap, let all four neighbors
// be read together, so throughput is one item a cycle when nothing stalls.
module bilinear_wrap_texture_sampler (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bwts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [bwts_pkg::CFG_DATA_BITS-1:0] cfg_data,
    bwts_stream_if.sink                        in_ch,
    bwts_stream_if.source                      out_ch
);
    import bwts_pkg::*;

    cfg_t cfg;
    logic fj_valid;
    logic fj_ready;
    job_t fj;
    logic bj_valid;
    logic bj_ready;
    job_t bj;

    bwts_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bwts_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_ch     (in_ch),
        .job_valid (fj_valid),
        .job       (fj),
        .job_ready (fj_ready)
    );

    bwts_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fj_valid),
        .wr_ready (fj_ready),
        .wr_data  (fj),
        .rd_valid (bj_valid),
        .rd_ready (bj_ready),
        .rd_data  (bj)
    );

    bwts_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (bj_valid),
        .job_ready (bj_ready),
        .job       (bj),
        .out_ch    (out_ch)
    );
endmodule

// ===== bench/tb_bilinear_wrap_texture_sampler.sv =====
// self-checking testbench for the bilinear wrap texture sampler
module tb_bilinear_wrap_texture_sampler;
    timeunit 1ns;
    timeprecision 1ps;
    import bwts_pkg::*;

    class sample_scoreboard;
        logic signed [COORD_BITS-1:0] u_scale, u_offset, v_scale, v_offset;
        logic [SIZE_BITS-1:0] tex_width, tex_height;
        logic texture_on;
        logic [TEXEL_BITS-1:0] flat_color;
        logic [TEXEL_BITS-1:0] texels [MAX_SIDE*MAX_SIDE];
        out_item_t expected_colors [$];
        int errors;

        function new();
            u_scale = 24'sh010000;
            u_offset = '0;
            v_scale = 24'sh010000;
            v_offset = '0;
            tex_width = SIZE_BITS'(MAX_SIDE);
            tex_height = SIZE_BITS'(MAX_SIDE);
            texture_on = 1'b0;
            flat_color = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_U_SCALE: u_scale = val[COORD_BITS-1:0];
                REG_U_OFFSET: u_offset = val[COORD_BITS-1:0];
                REG_V_SCALE: v_scale = val[COORD_BITS-1:0];
                REG_V_OFFSET: v_offset = val[COORD_BITS-1:0];
                REG_TEX_WIDTH: tex_width = val[SIZE_BITS-1:0];
                REG_TEX_HEIGHT: tex_height = val[SIZE_BITS-1:0];
                REG_TEXTURE_ON: texture_on = val[0];
                default: flat_color = val[TEXEL_BITS-1:0];
            endcase
        endfunction

        function int side_of(logic [SIZE_BITS-1:0] s);
            if (s == 0)
                return 1;
            if (s > MAX_SIDE)
                return MAX_SIDE;
            return int'(s);
        endfunction

        function void wrap_axis(logic signed [COORD_BITS-1:0] sc,
                                logic signed [COORD_BITS-1:0] off,
                                logic signed [COORD_BITS-1:0] crd, int side,
                                output int idx, output int nidx,
                                output logic [FRAC_BITS-1:0] w);
            logic signed [47:0] prod;
            logic [31:0] frac;
            logic [40:0] pos;
            prod = sc * crd;
            frac = prod[31:0] + {off[15:0], 16'b0};
            pos = 41'(frac) * 41'(side);
            idx = int'(pos[40:32]);
            w = pos[31:16];
            if (idx >= side)
                idx = side - 1;
            nidx = (idx + 1 == side) ? 0 : idx + 1;
        endfunction

        // four neighbor addresses: (x,y) (nx,y) (x,ny) (nx,ny)
        function void taps(in_item_t it, output int addr [4], output logic [FRAC_BITS-1:0] dx,
                           output logic [FRAC_BITS-1:0] dy);
            int x, nx, y, ny;
            wrap_axis(u_scale, u_offset, it.u_coord, side_of(tex_width), x, nx, dx);
            wrap_axis(v_scale, v_offset, it.v_coord, side_of(tex_height), y, ny, dy);
            addr[0] = y * MAX_SIDE + x;
            addr[1] = y * MAX_SIDE + nx;
            addr[2] = ny * MAX_SIDE + x;
            addr[3] = ny * MAX_SIDE + nx;
        endfunction

        function void note(in_item_t it);
            int addr [4];
            logic [FRAC_BITS-1:0] dx, dy;
            longint unsigned r0, r1, c;
            out_item_t e;
            if (it.op == OP_WRITE)
            begin
                texels[int'(it.texel_row) * MAX_SIDE + int'(it.texel_col)] =
                    {it.texel_red, it.texel_green, it.texel_blue};
                return;
            end
            if (!texture_on)
            begin
                e = {flat_color, 1'b0};
            end
            else
            begin
                taps(it, addr, dx, dy);
                for (int ch = 0; ch < 3; ch++)
                begin
                    r0 = longint'(texels[addr[0]][47-16*ch -: 16]) * (65536 - longint'(dx))
                       + longint'(texels[addr[1]][47-16*ch -: 16]) * longint'(dx);
                    r1 = longint'(texels[addr[2]][47-16*ch -: 16]) * (65536 - longint'(dx))
                       + longint'(texels[addr[3]][47-16*ch -: 16]) * longint'(dx);
                    c = r0 * (65536 - longint'(dy)) + r1 * longint'(dy);
                    c = (c + 64'h8000_0000) >> 32;
                    if (ch == 0)
                        e.out_red = c[15:0];
                    else if (ch == 1)
                        e.out_green = c[15:0];
                    else
                        e.out_blue = c[15:0];
                end
                e.from_texture = 1'b1;
            end
            expected_colors.insert(expected_colors.size(), e);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check(out_item_t got);
            out_item_t e;
            if (expected_colors.size() == 0)
            begin
                report("result with nothing expected");
                return;
            end
            e = expected_colors.pop_front();
            if (got.out_red !== e.out_red)
                report($sformatf("red %h, expected %h", got.out_red, e.out_red));
            if (got.out_green !== e.out_green)
                report($sformatf("green %h, expected %h", got.out_green, e.out_green));
            if (got.out_blue !== e.out_blue)
                report($sformatf("blue %h, expected %h", got.out_blue, e.out_blue));
            if (got.from_texture !== e.from_texture)
                report($sformatf("from_texture %b, expected %b",
                                 got.from_texture, e.from_texture));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    bwts_stream_if #(.payload_t(in_item_t)) in_ch ();
    bwts_stream_if #(.payload_t(out_item_t)) out_ch ();

    sample_scoreboard sb;
    bit written [MAX_SIDE*MAX_SIDE];
    bit no_gaps;
    int idle_cycles = 0;

    bilinear_wrap_texture_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sink side: random stalls, check every transfer
    initial
    begin
        int stall;
        stall = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check(out_ch.data);
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                stall = pick_gap();
                out_ch.ready <= (stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 4000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task send(in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note(it);
    endtask

    task write_texel(int col, int row, logic [TEXEL_BITS-1:0] color);
        in_item_t it;
        it = in_item_t'($urandom());
        it.u_coord = COORD_BITS'($urandom());
        it.v_coord = COORD_BITS'($urandom());
        it.op = OP_WRITE;
        it.texel_col = col[7:0];
        it.texel_row = row[7:0];
        {it.texel_red, it.texel_green, it.texel_blue} = color;
        written[row * MAX_SIDE + col] = 1'b1;
        send(it);
    endtask

    function automatic logic [TEXEL_BITS-1:0] rand_color();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return TEXEL_BITS'({$urandom(), $urandom()});
        endcase
    endfunction

    // fill any unwritten neighbor first so no sample reads an empty texel
    task sample_at(logic signed [COORD_BITS-1:0] u, logic signed [COORD_BITS-1:0] v);
        in_item_t it;
        int addr [4];
        logic [FRAC_BITS-1:0] dx, dy;
        it = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.op = OP_SAMPLE;
        it.u_coord = u;
        it.v_coord = v;
        if (sb.texture_on)
        begin
            sb.taps(it, addr, dx, dy);
            for (int k = 0; k < 4; k++)
                if (!written[addr[k]])
                    write_texel(addr[k] % MAX_SIDE, addr[k] / MAX_SIDE, rand_color());
        end
        send(it);
    endtask

    task drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_colors.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [COORD_BITS-1:0] rand_q();
        case ($urandom_range(0, 7))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h010000;
            3: return 24'hFF0000;
            4: return 24'(($urandom_range(0, 8) << 14));
            default: return COORD_BITS'($urandom());
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] rand_side();
        case ($urandom_range(0, 9))
            0: return 9'd1;
            1: return 9'd256;
            2: return 9'd0;
            3: return SIZE_BITS'($urandom_range(257, 511));
            4: return 9'd2;
            default: return SIZE_BITS'($urandom_range(1, 24));
        endcase
    endfunction

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        no_gaps = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flat color at reset, then at its extremes
        sample_at(24'h7FFFFF, 24'h800000);
        drain();
        set_reg(REG_FLAT_COLOR, 48'hFFFF_FFFF_FFFF);
        sample_at(24'h000000, 24'h000000);
        write_texel(255, 255, 48'hFFFF_FFFF_FFFF);
        write_texel(0, 0, '0);
        drain();
        set_reg(REG_FLAT_COLOR, CFG_DATA_BITS'({$urandom(), $urandom()}));
        set_reg(REG_TEXTURE_ON, 48'd1);
        sample_at(24'h008000, 24'h00C000);
        sample_at(24'h7FFFFF, 24'h7FFFFF);
        sample_at(24'h800000, 24'h800001);
        sample_at(24'hFFFFFF, 24'h000001);
        drain();
        // out of range sides, coordinate overflow, offsets
        set_reg(REG_TEX_WIDTH, 48'd0);
        set_reg(REG_TEX_HEIGHT, 48'd511);
        set_reg(REG_U_SCALE, 48'h7FFFFF);
        set_reg(REG_V_SCALE, 48'h800000);
        set_reg(REG_U_OFFSET, 48'h800000);
        set_reg(REG_V_OFFSET, 48'h7FFFFF);
        sample_at(24'h7FFFFF, 24'h7FFFFF);
        sample_at(24'h800000, 24'h800000);
        sample_at(24'h123456, 24'hFEDCBA);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            int w, h;
            no_gaps = ($urandom_range(0, 3) == 0);
            set_reg(REG_U_SCALE, CFG_DATA_BITS'(rand_q()));
            set_reg(REG_U_OFFSET, CFG_DATA_BITS'(rand_q()));
            set_reg(REG_V_SCALE, CFG_DATA_BITS'(rand_q()));
            set_reg(REG_V_OFFSET, CFG_DATA_BITS'(rand_q()));
            set_reg(REG_TEX_WIDTH, CFG_DATA_BITS'(rand_side()));
            set_reg(REG_TEX_HEIGHT, CFG_DATA_BITS'(rand_side()));
            set_reg(REG_TEXTURE_ON, (phase % 4 == 3) ? 48'd0 : 48'd1);
            set_reg(REG_FLAT_COLOR, CFG_DATA_BITS'({$urandom(), $urandom()}));
            w = sb.side_of(sb.tex_width);
            h = sb.side_of(sb.tex_height);
            for (int n = 0; n < 36; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 3) == 0)
                        write_texel($urandom_range(0, 255), $urandom_range(0, 255), rand_color());
                    else
                        write_texel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                                    rand_color());
                end
                else
                    sample_at(COORD_BITS'($urandom()), COORD_BITS'($urandom()));
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
